FILE: design/fir_interpolator_2x_25tap_macros.svh
// Assertion helpers used by the top-level design file.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef FIR_INTERPOLATOR_2X_25TAP_MACROS_SVH
`define FIR_INTERPOLATOR_2X_25TAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FI2X_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FI2X_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fi2x_pkg.sv
package fi2x_pkg;

  // Sizes of the filter and its datapath.
  localparam int TAPS        = 25;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int DIGIT_BITS  = 8;
  localparam int DIGITS      = SAMPLE_BITS / DIGIT_BITS;
  localparam int DSEL_BITS   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int TAP_BITS    = $clog2(TAPS);
  localparam int PROD_BITS   = COEF_BITS + DIGIT_BITS + 1;
  localparam int ACC_BITS    = 36;
  localparam int ROUND_SHIFT = 16;
  localparam int RES_BITS    = ACC_BITS - ROUND_SHIFT;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // Symmetric lowpass taps in Q1.17, index 0 applies to the oldest sample.
  localparam coef_t COEF [TAPS] = '{
    18'sd472,    18'sd391,    -18'sd901,   -18'sd2317,  -18'sd1177,
    18'sd2654,   18'sd4283,   -18'sd957,   -18'sd8806,  -18'sd6675,
    18'sd12646,  18'sd38962,  18'sd51339,  18'sd38962,  18'sd12646,
    -18'sd6675,  -18'sd8806,  -18'sd957,   18'sd4283,   18'sd2654,
    -18'sd1177,  -18'sd2317,  -18'sd901,   18'sd391,    18'sd472
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic                 clr;
    logic                 en;
    logic [DSEL_BITS-1:0] dsel;
  } mac_ctrl_t;

endpackage

FILE: design/fi2x_mac.sv
module fi2x_mac import fi2x_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mac_ctrl_t ctrl,
  input  sample_t   sample,
  input  coef_t     coef,
  output acc_t      acc
);

  logic [DIGIT_BITS-1:0]       digit;
  logic signed [DIGIT_BITS:0]  operand;
  logic signed [PROD_BITS-1:0] prod;
  logic                        prod_vld;
  logic [DSEL_BITS-1:0]        prod_dsel;
  acc_t                        ext;
  acc_t                        term;

  // Pick one digit of the sample; only the top digit carries the sign.
  always_comb begin
    digit = sample[int'(ctrl.dsel) * DIGIT_BITS +: DIGIT_BITS];
    if (ctrl.dsel == DSEL_BITS'(DIGITS - 1)) begin
      operand = {digit[DIGIT_BITS-1], digit};
    end else begin
      operand = {1'b0, digit};
    end
  end

  // Registered partial product of the coefficient and one digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.en;
    end
    prod      <= coef * operand;
    prod_dsel <= ctrl.dsel;
  end

  // Weight the partial product by its digit position.
  always_comb begin
    ext  = {{(ACC_BITS - PROD_BITS){prod[PROD_BITS-1]}}, prod};
    term = ext << (DIGIT_BITS * int'(prod_dsel));
  end

  // Exact accumulation of all weighted partial products.
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + term;
    end
  end

endmodule

FILE: design/fir_interpolator_2x_25tap.sv
// Two-times interpolator with a symmetric 25-tap lowpass filter. Each input
// item produces two output items: the filtered output after the new sample
// enters the delay line, then the output after an inserted zero, which comes
// with last set. Outputs are doubled, rounded half up to Q1.15 and saturated.
// The next item can be accepted in the cycle after the second output is
// loaded. Each output walks the 25 taps with the sample split into two 8-bit
// digits, one digit per cycle through a single 18x9 multiplier, followed by
// a finish step that drains the product register and a rounding step that
// loads the output register. up_stall stays high from after acceptance until
// the unit is idle again after the second output. An output that is not
// taken holds the unit at its rounding step until it is.
`include "fir_interpolator_2x_25tap_macros.svh"

module fir_interpolator_2x_25tap import fi2x_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  sample_t sample_in,
  input  logic    up_valid,
  output logic    up_stall,
  output sample_t sample_out,
  output logic    last,
  output logic    dn_valid,
  input  logic    dn_stall
);

  localparam logic signed [RES_BITS-1:0] RES_MAX =
    RES_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RES_BITS-1:0] RES_MIN = -RES_MAX - RES_BITS'(1);
  localparam acc_t ROUND_HALF = ACC_BITS'(1 << (ROUND_SHIFT - 1));

  state_t                state;
  state_t                state_next;
  sample_t               line [TAPS];
  logic [TAP_BITS-1:0]   tap;
  logic [DSEL_BITS-1:0]  dsel;
  logic                  phase;
  logic                  accept;
  logic                  emit_go;
  logic                  out_free;
  logic                  walk_done;
  logic                  push;
  mac_ctrl_t             mac_ctrl;
  acc_t                  acc;
  acc_t                  rnd;
  logic signed [RES_BITS-1:0] shifted;
  sample_t               sat;

  assign accept    = up_valid && !up_stall;
  assign out_free  = !dn_valid || !dn_stall;
  assign walk_done = (tap == TAP_BITS'(TAPS - 1)) && (dsel == DSEL_BITS'(DIGITS - 1));
  assign push      = accept || (emit_go && !phase);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and controls for the multiply-accumulate unit.
  always_comb begin
    state_next    = state;
    up_stall      = 1'b1;
    emit_go       = 1'b0;
    mac_ctrl.en   = 1'b0;
    mac_ctrl.dsel = dsel;
    case (state)
      ST_IDLE: begin
        up_stall = 1'b0;
        if (up_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        mac_ctrl.en = 1'b1;
        if (walk_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_go    = 1'b1;
          state_next = phase ? ST_IDLE : ST_RUN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    mac_ctrl.clr = push;
  end

  // Delay line as a shift line: index 0 holds the oldest sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        line[i] <= '0;
      end
    end else if (push) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        line[i] <= line[i + 1];
      end
      line[TAPS-1] <= accept ? sample_in : '0;
    end
  end

  // Tap and digit counters, and the phase of the output pair. The tap count
  // stops at the last tap so the delay line is never read past its end.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap   <= '0;
      dsel  <= '0;
      phase <= 1'b0;
    end else begin
      if (push) begin
        tap  <= '0;
        dsel <= '0;
      end else if (state == ST_RUN) begin
        if (dsel == DSEL_BITS'(DIGITS - 1)) begin
          dsel <= '0;
          if (!walk_done) begin
            tap <= tap + TAP_BITS'(1);
          end
        end else begin
          dsel <= dsel + DSEL_BITS'(1);
        end
      end
      if (accept) begin
        phase <= 1'b0;
      end else if (emit_go && !phase) begin
        phase <= 1'b1;
      end
    end
  end

  fi2x_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (line[tap]),
    .coef   (COEF[tap]),
    .acc    (acc)
  );

  // Gain of two, round half up to Q1.15, then saturate.
  always_comb begin
    rnd     = acc + ROUND_HALF;
    shifted = RES_BITS'(rnd >>> ROUND_SHIFT);
    if (shifted > RES_MAX) begin
      sat = sample_t'(RES_MAX);
    end else if (shifted < RES_MIN) begin
      sat = sample_t'(RES_MIN);
    end else begin
      sat = sample_t'(shifted);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (emit_go) begin
      dn_valid <= 1'b1;
    end else if (!dn_stall) begin
      dn_valid <= 1'b0;
    end
    if (emit_go) begin
      sample_out <= sat;
      last       <= phase;
    end
  end

  // An accepted item starts a fresh walk over the taps.
  `FI2X_ASSERT_NEXT(a_start_walk, accept, (state == ST_RUN) && (tap == '0) && (dsel == '0), "item did not start a tap walk")
  // During the second output the newest entry is the inserted zero.
  `FI2X_ASSERT_SAME(a_zero_pushed, (state == ST_RUN) && phase, line[TAPS-1] == '0, "inserted zero missing")
  // After the last output of a pair the unit returns to idle.
  `FI2X_ASSERT_NEXT(a_pair_done, emit_go && phase, state == ST_IDLE, "unit busy after second output")
  // A new output only appears from the rounding step.
  `FI2X_ASSERT_SAME(a_out_source, $rose(dn_valid), $past(state) == ST_EMIT, "output loaded outside rounding step")

endmodule
